// ===== hw/rtl/hex_record_parser_defines.svh =====
// Assertion macros for the hex record parser checker.
// Depends on nothing; expects clk_i and rst_ni in the using scope.
`ifndef HEX_RECORD_PARSER_DEFINES_SVH
`define HEX_RECORD_PARSER_DEFINES_SVH

// checked only while out of reset
`define HRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HRP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/hrp_pkg.sv =====
// Shared types, codes and helpers for the hex record parser.
// No dependencies.
package hrp_pkg;

  localparam int unsigned PosW = 4;

  localparam logic [PosW-1:0] POS_COLON = 4'd0;
  localparam logic [PosW-1:0] POS_HDR_LAST = 4'd8;
  localparam logic [PosW-1:0] POS_HI = 4'd9;
  localparam logic [PosW-1:0] POS_LO = 4'd10;
  localparam logic [PosW-1:0] POS_DONE = 4'd11;
  localparam logic [PosW-1:0] POS_COUNT_LAST = 4'd2;
  localparam logic [PosW-1:0] POS_OFFSET_LAST = 4'd6;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;
  localparam logic [7:0] REC_START_LIN = 8'h05;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_EOF  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_COLON = 3'd0,
    ERR_BAD_HEX  = 3'd1,
    ERR_SHORT    = 3'd2,
    ERR_REC_TYPE = 3'd3,
    ERR_NO_END   = 3'd4
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    err_e        error_code;
  } res_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic [7:0] needed_bytes(input logic [7:0] rec, input logic [7:0] cnt);
    logic [7:0] n;
    n = cnt;
    if (rec == REC_EXT_LIN && cnt < 8'd2) begin
      n = 8'd2;
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/hrp_in_stage.sv =====
// Input register of the hex record parser: holds one character word.
// Depends on nothing.
module hrp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       final_req_i,
  input  logic       sink_ready_i,
  output logic       advance_o,
  output logic [7:0] char_o,
  output logic       final_o
);

  logic       valid_q;
  logic [7:0] char_q;
  logic       final_q;

  assign advance_o  = valid_q && sink_ready_i;
  assign in_ready_o = !valid_q || sink_ready_i;
  assign char_o     = char_q;
  assign final_o    = final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q  <= char_in_i;
      final_q <= final_req_i;
    end
  end

endmodule

// ===== hw/rtl/hrp_parser.sv =====
// Parser state and its one-step update for each character word.
// Depends on hrp_pkg.
module hrp_parser
  import hrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       final_i,
  output logic       res_valid_o,
  output res_t       res_o
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_ENDED = 2'd1,
    ST_FAIL  = 2'd2
  } run_e;

  run_e            status_q, status_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     acc_q, acc_d;
  logic [7:0]      count_q, count_d;
  logic [15:0]     offset_q, offset_d;
  logic [7:0]      rec_q, rec_d;
  logic [7:0]      idx_q, idx_d;
  logic [15:0]     base_hi_q, base_hi_d;

  logic [4:0]  digit;
  logic [15:0] acc_shift;
  logic [7:0]  idx_inc;
  logic [31:0] byte_addr;

  assign digit     = hex_digit(char_i);
  assign acc_shift = {acc_q[11:0], digit[3:0]};
  assign idx_inc   = idx_q + 8'd1;
  assign byte_addr = {base_hi_q, 16'h0000} + {16'h0000, offset_q} + {24'h00_0000, idx_q};

  always_comb begin
    status_d    = status_q;
    pos_d       = pos_q;
    acc_d       = acc_q;
    count_d     = count_q;
    offset_d    = offset_q;
    rec_d       = rec_q;
    idx_d       = idx_q;
    base_hi_d   = base_hi_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, address: 32'h0, data_byte: 8'h00,
                    error_code: ERR_NO_COLON};

    if (step_i && status_q == ST_RUN) begin
      if (char_i == CHAR_CR) begin
        // skipped anywhere
      end else if (char_i == CHAR_LF) begin
        if (pos_q == POS_COLON) begin
          status_d = ST_FAIL;
          res_valid_o = 1'b1;
          res_o.kind = KIND_ERR;
          res_o.error_code = ERR_NO_COLON;
        end else if (pos_q < POS_DONE) begin
          status_d = ST_FAIL;
          res_valid_o = 1'b1;
          res_o.kind = KIND_ERR;
          res_o.error_code = ERR_SHORT;
        end else begin
          pos_d = POS_COLON;
          acc_d = 16'h0;
          idx_d = 8'h00;
        end
      end else if (pos_q == POS_COLON) begin
        if (char_i != CHAR_COLON) begin
          status_d = ST_FAIL;
          res_valid_o = 1'b1;
          res_o.kind = KIND_ERR;
          res_o.error_code = ERR_NO_COLON;
        end else begin
          pos_d = pos_q + 4'd1;
          acc_d = 16'h0;
        end
      end else if (pos_q > POS_LO) begin
        // trailing characters up to line feed
      end else if (!digit[4]) begin
        status_d = ST_FAIL;
        res_valid_o = 1'b1;
        res_o.kind = KIND_ERR;
        res_o.error_code = ERR_BAD_HEX;
      end else begin
        acc_d = acc_shift;
        if (pos_q <= POS_HDR_LAST) begin
          if (pos_q == POS_COUNT_LAST) count_d = acc_shift[7:0];
          if (pos_q == POS_OFFSET_LAST) offset_d = acc_shift;
          if (pos_q < POS_HDR_LAST) begin
            pos_d = pos_q + 4'd1;
          end else begin
            rec_d = acc_shift[7:0];
            acc_d = 16'h0;
            idx_d = 8'h00;
            if (acc_shift[7:0] == REC_EOF) begin
              status_d = ST_ENDED;
              pos_d = POS_DONE;
              res_valid_o = 1'b1;
              res_o.kind = KIND_EOF;
            end else if (acc_shift[7:0] != REC_DATA && acc_shift[7:0] != REC_EXT_LIN &&
                         acc_shift[7:0] != REC_START_LIN) begin
              status_d = ST_FAIL;
              res_valid_o = 1'b1;
              res_o.kind = KIND_ERR;
              res_o.error_code = ERR_REC_TYPE;
            end else begin
              pos_d = (needed_bytes(acc_shift[7:0], count_q) == 8'h00) ? POS_DONE : POS_HI;
            end
          end
        end else if (pos_q == POS_HI) begin
          pos_d = POS_LO;
        end else begin
          if (rec_q == REC_DATA) begin
            res_valid_o = 1'b1;
            res_o.kind = KIND_DATA;
            res_o.address = byte_addr;
            res_o.data_byte = acc_shift[7:0];
          end
          if (rec_q == REC_EXT_LIN && idx_q == 8'd1) base_hi_d = acc_shift;
          idx_d = idx_inc;
          pos_d = (idx_inc == needed_bytes(rec_q, count_q)) ? POS_DONE : POS_HI;
        end
      end

      // file ends while still running: replaces any data word of this step
      if (final_i && status_d == ST_RUN) begin
        status_d = ST_FAIL;
        res_valid_o = 1'b1;
        res_o = '{kind: KIND_ERR, address: 32'h0, data_byte: 8'h00,
                  error_code: (pos_d != POS_COLON && pos_d < POS_DONE) ? ERR_SHORT
                                                                       : ERR_NO_END};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_RUN;
      pos_q     <= POS_COLON;
      acc_q     <= 16'h0;
      count_q   <= 8'h00;
      offset_q  <= 16'h0;
      rec_q     <= 8'h00;
      idx_q     <= 8'h00;
      base_hi_q <= 16'h0;
    end else begin
      status_q  <= status_d;
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      count_q   <= count_d;
      offset_q  <= offset_d;
      rec_q     <= rec_d;
      idx_q     <= idx_d;
      base_hi_q <= base_hi_d;
    end
  end

endmodule

// ===== hw/rtl/hrp_out_stage.sv =====
// Result register of the hex record parser.
// Depends on hrp_pkg.
module hrp_out_stage
  import hrp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic sink_ready_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign out_valid_o  = valid_q;
  assign res_o        = res_q;
  assign sink_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hw/rtl/hex_record_parser.sv =====
// Intel HEX parser: one character word per cycle unless the result stage stalls;
// at most one result word each, registered in the result stage when its character
// leaves the input stage. The parser state updates once per character.
// Reset (asynchronous, active low) clears both stage valids and the parser state.
// Depends on hrp_pkg, hrp_in_stage, hrp_parser and hrp_out_stage.
module hex_record_parser
  import hrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_in_i,
  input  logic        final_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] address_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  error_code_o
);

  logic       sink_ready;
  logic       advance;
  logic [7:0] char_s;
  logic       final_s;
  logic       res_valid;
  res_t       res_next;
  res_t       res_out;

  hrp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .final_req_i  (final_req_i),
    .sink_ready_i (sink_ready),
    .advance_o    (advance),
    .char_o       (char_s),
    .final_o      (final_s)
  );

  hrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .char_i      (char_s),
    .final_i     (final_s),
    .res_valid_o (res_valid),
    .res_o       (res_next)
  );

  hrp_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && res_valid),
    .res_i        (res_next),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sink_ready_o (sink_ready),
    .res_o        (res_out)
  );

  assign kind_o       = res_out.kind;
  assign address_o    = res_out.address;
  assign data_byte_o  = res_out.data_byte;
  assign error_code_o = res_out.error_code;

endmodule

// ===== hw/rtl/hrp_checker.sv =====
// Port-level checks for hex_record_parser, bound to the top level.
// Depends on hrp_pkg and hex_record_parser_defines.svh.
`include "hex_record_parser_defines.svh"

module hrp_checker
  import hrp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [31:0] address_o,
  input logic [7:0]  data_byte_o,
  input logic [2:0]  error_code_o
);

  logic [44:0] word;
  logic [39:0] payload;
  logic        stalled;
  logic        word_taken;
  logic        not_data;

  assign word       = {kind_o, address_o, data_byte_o, error_code_o};
  assign payload    = {address_o, data_byte_o};
  assign stalled    = out_valid_o && !out_ready_i;
  assign word_taken = out_valid_o && out_ready_i;
  assign not_data   = kind_o != KIND_DATA;

  `HRP_ASSERT(a_out_hold, stalled |=> out_valid_o && $stable(word), "stalled word changed")
  `HRP_ASSERT(a_last_word, word_taken && not_data |=> !out_valid_o, "word after end or error")
  `HRP_ASSERT(a_err_fields, out_valid_o && not_data |-> payload == 40'h0, "stray payload")
  `HRP_ASSERT(a_ready_free, !out_valid_o |-> in_ready_o, "input stalled while empty")
  `HRP_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "result word right after reset")

endmodule

bind hex_record_parser hrp_checker u_hrp_checker (.*);
